/* rtl/core/utf8_stream_decoder_defines.svh */
// Assertion macros shared by the UTF-8 stream decoder modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define U8SD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define U8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/u8sd_pkg.sv */
// Package for the UTF-8 stream decoder: result types, status codes and lead-byte constants.
// No dependencies.
package u8sd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CpW    = 31;
    localparam int unsigned OwedW  = 3;
    localparam int unsigned TdataW = 32;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        status_t        status;
        logic           at_buffer_end;
    } result_t;

    typedef struct packed {
        logic             emit;
        result_t          result;
        logic [OwedW-1:0] owed_next;
        logic [CpW-1:0]   partial_next;
    } step_t;

    // Lead byte class masks and the patterns they must match.
    localparam logic [ByteW-1:0] LEAD2_MASK = 8'b1110_0000;
    localparam logic [ByteW-1:0] LEAD2_PAT  = 8'b1100_0000;
    localparam logic [ByteW-1:0] LEAD3_MASK = 8'b1111_0000;
    localparam logic [ByteW-1:0] LEAD3_PAT  = 8'b1110_0000;
    localparam logic [ByteW-1:0] LEAD4_MASK = 8'b1111_1000;
    localparam logic [ByteW-1:0] LEAD4_PAT  = 8'b1111_0000;
    localparam logic [ByteW-1:0] LEAD5_MASK = 8'b1111_1100;
    localparam logic [ByteW-1:0] LEAD5_PAT  = 8'b1111_1000;
    localparam logic [ByteW-1:0] LEAD6_MASK = 8'b1111_1110;
    localparam logic [ByteW-1:0] LEAD6_PAT  = 8'b1111_1100;

    // Payload bits carried by each lead form and by a continuation byte.
    localparam logic [ByteW-1:0] PAY2_MASK = 8'b0001_1111;
    localparam logic [ByteW-1:0] PAY3_MASK = 8'b0000_1111;
    localparam logic [ByteW-1:0] PAY4_MASK = 8'b0000_0111;
    localparam logic [ByteW-1:0] PAY5_MASK = 8'b0000_0011;
    localparam logic [ByteW-1:0] PAY6_MASK = 8'b0000_0001;
    localparam logic [ByteW-1:0] CONT_MASK = 8'b0011_1111;

endpackage

/* rtl/core/u8sd_step.sv */
// Combinational decode step: one byte against the running state gives next state and result.
// Depends on u8sd_pkg.
module u8sd_step (
    input  logic [u8sd_pkg::ByteW-1:0] data_byte,
    input  logic                       buffer_end,
    input  logic [u8sd_pkg::OwedW-1:0] owed,
    input  logic [u8sd_pkg::CpW-1:0]   partial,
    output u8sd_pkg::step_t            step
);
    import u8sd_pkg::*;

    logic [CpW-1:0]   shifted;
    logic [OwedW-1:0] owed_dec;
    logic [5:0]       cont_bits;

    assign cont_bits = 6'(data_byte & CONT_MASK);
    assign shifted   = {partial[CpW-7:0], cont_bits};
    assign owed_dec  = owed - OwedW'(1);

    always_comb
    begin
        logic [OwedW-1:0] lead_owed;
        logic [ByteW-1:0] lead_pay;
        logic             lead_ok;

        lead_owed = '0;
        lead_pay  = '0;
        lead_ok   = 1'b1;

        step.emit                 = 1'b0;
        step.result.code_point    = '0;
        step.result.status        = ST_OK;
        step.result.at_buffer_end = buffer_end;
        step.owed_next            = '0;
        step.partial_next         = '0;

        priority if ((data_byte & LEAD2_MASK) == LEAD2_PAT)
        begin
            lead_owed = OwedW'(1);
            lead_pay  = data_byte & PAY2_MASK;
        end
        else if ((data_byte & LEAD3_MASK) == LEAD3_PAT)
        begin
            lead_owed = OwedW'(2);
            lead_pay  = data_byte & PAY3_MASK;
        end
        else if ((data_byte & LEAD4_MASK) == LEAD4_PAT)
        begin
            lead_owed = OwedW'(3);
            lead_pay  = data_byte & PAY4_MASK;
        end
        else if ((data_byte & LEAD5_MASK) == LEAD5_PAT)
        begin
            lead_owed = OwedW'(4);
            lead_pay  = data_byte & PAY5_MASK;
        end
        else if ((data_byte & LEAD6_MASK) == LEAD6_PAT)
        begin
            lead_owed = OwedW'(5);
            lead_pay  = data_byte & PAY6_MASK;
        end
        else
        begin
            lead_ok = 1'b0;
        end

        priority if (owed != '0)
        begin
            // Continuation byte; its top two bits are not checked.
            if (owed_dec == '0)
            begin
                step.emit              = 1'b1;
                step.result.code_point = shifted;
            end
            else if (buffer_end)
            begin
                step.emit          = 1'b1;
                step.result.status = ST_TRUNCATED;
            end
            else
            begin
                step.owed_next    = owed_dec;
                step.partial_next = shifted;
            end
        end
        else if (!data_byte[ByteW-1])
        begin
            step.emit              = 1'b1;
            step.result.code_point = CpW'(data_byte);
        end
        else if (!lead_ok)
        begin
            step.emit          = 1'b1;
            step.result.status = ST_BAD_LEAD;
        end
        else if (buffer_end)
        begin
            step.emit          = 1'b1;
            step.result.status = ST_TRUNCATED;
        end
        else
        begin
            step.owed_next    = lead_owed;
            step.partial_next = CpW'(lead_pay);
        end
    end

endmodule

/* rtl/core/u8sd_out_buf.sv */
// Two-entry result buffer (output register plus skid register) for the decoder results.
// Depends on u8sd_pkg and the assertion macro header.
`include "utf8_stream_decoder_defines.svh"
module u8sd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  u8sd_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output u8sd_pkg::result_t out_data
);
    import u8sd_pkg::*;

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next = in_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `U8SD_ASSERT(a_skid_behind_main, !skid_valid_reg || main_valid_reg, "skid full with output empty")
    `U8SD_ASSERT_NEXT(a_stall_fills_skid, main_valid_reg && !out_ready && push, skid_valid_reg, "stalled result lost")

endmodule

/* rtl/core/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder: state registers, decode step and result buffer.
// Depends on u8sd_pkg, u8sd_step, u8sd_out_buf and the assertion macro header.
//
// Streaming decoder for the original 31-bit UTF-8 form, with sequences of one to six
// bytes. Each request on the slave side carries one byte in s_tdata and, in s_tlast, a
// flag that marks the last byte of a buffer. When a request is taken, the byte is
// decoded against the count of continuation bytes still owed and the partial code point,
// both held in registers, and a finished result goes straight into the result buffer.
// The block sustains one byte per clock while s_tready is high; the only loop is the
// registered update of the owed count and the six-bit shift-in of the partial value. The
// output has a register and a skid register behind it, so s_tready stays high while one
// result waits and drops only when both are full; results reach the master side from the
// output register. Bytes that leave a sequence open produce no result. Continuation bytes
// are merged by their low six bits without checking the top two bits. Status on m_tuser
// is ok, invalid lead (a continuation byte, 0xFE or 0xFF seen while idle) or truncated (a
// buffer that ends inside a sequence, including a multi-byte lead that is itself the last
// byte); error results carry a zero code point, and the decoder returns to idle after
// either error. m_tlast copies the end flag of the byte that produced the result.
`include "utf8_stream_decoder_defines.svh"
module utf8_stream_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [u8sd_pkg::ByteW-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                        s_tlast,   // buffer_end
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [u8sd_pkg::TdataW-1:0] m_tdata,   // [30:0] code_point, [31] zero
    output logic [1:0]                  m_tuser,   // [1:0] status
    output logic                        m_tlast    // at_buffer_end
);
    import u8sd_pkg::*;

    logic [OwedW-1:0] owed_reg;
    logic [OwedW-1:0] owed_next;
    logic [CpW-1:0]   partial_reg;
    logic [CpW-1:0]   partial_next;
    logic             accept;
    step_t            step;
    result_t          out_result;

    // A request is taken whenever the result buffer has room for one more result.
    assign accept = s_tvalid && s_tready;

    u8sd_step u_step (
        .data_byte  (s_tdata),
        .buffer_end (s_tlast),
        .owed       (owed_reg),
        .partial    (partial_reg),
        .step       (step)
    );

    // State moves only on an accepted byte.
    assign owed_next    = accept ? step.owed_next    : owed_reg;
    assign partial_next = accept ? step.partial_next : partial_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg    <= '0;
            partial_reg <= '0;
        end
        else
        begin
            owed_reg    <= owed_next;
            partial_reg <= partial_next;
        end
    end

    u8sd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid && step.emit),
        .in_ready  (s_tready),
        .in_data   (step.result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {1'b0, out_result.code_point};
    assign m_tuser = out_result.status;
    assign m_tlast = out_result.at_buffer_end;

    `U8SD_ASSERT(a_owed_range, owed_reg <= OwedW'(5), "owed count beyond six-byte form")
    `U8SD_ASSERT(a_idle_partial_clear, owed_reg != '0 || partial_reg == '0, "idle with stale partial value")
    `U8SD_ASSERT(a_error_zero_cp, !m_tvalid || m_tuser == ST_OK || m_tdata == '0, "error result with nonzero code point")
    `U8SD_ASSERT_NEXT(a_silent_byte_opens, accept && !step.emit, owed_reg != '0, "byte without result left decoder idle")

endmodule
